// ===== src/gof_pkg.sv =====
// Shared types and constants for the glyph outline flattener.
// Used by the interfaces, the register block, the controller and the datapath.
// No dependencies.
package gof_pkg;

    // Field widths
    localparam int OP_W      = 3;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SCALE_W   = 26;
    localparam int MUL_B_W   = SCALE_W + 1;
    localparam int PT_W      = 36;
    localparam int SEP_W     = 2;
    localparam int NL_W      = 3;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 4;

    // Fraction bits dropped from a scaled point (24 in scale, 16 kept)
    localparam int PT_SHIFT  = 8;

    // Report values pass the multiplier at unit gain (1.0 with 24 fraction bits)
    localparam logic signed [MUL_B_W-1:0] REPORT_GAIN = 27'sd16777216;

    // Reset values of the extremes
    localparam logic signed [COORD_W-1:0] MIN_X_INIT = 16'sd1000;
    localparam logic signed [COORD_W-1:0] MAX_Y_INIT = -16'sd1000;

    // Opcodes
    localparam logic [OP_W-1:0] OP_MOVE   = 3'd0;
    localparam logic [OP_W-1:0] OP_LINE   = 3'd1;
    localparam logic [OP_W-1:0] OP_QUAD   = 3'd2;
    localparam logic [OP_W-1:0] OP_CUBIC  = 3'd3;
    localparam logic [OP_W-1:0] OP_BEGIN  = 3'd4;
    localparam logic [OP_W-1:0] OP_REPORT = 3'd5;

    // Separator codes
    localparam logic [SEP_W-1:0] SEP_FIRST  = 2'd0;
    localparam logic [SEP_W-1:0] SEP_NEW    = 2'd1;
    localparam logic [SEP_W-1:0] SEP_CONT   = 2'd2;
    localparam logic [SEP_W-1:0] SEP_REPORT = 2'd3;

    // Register indexes (byte address is 4 * index)
    typedef enum logic [1:0] {
        REG_MEASURE_MODE,
        REG_OUTPUT_ENABLE,
        REG_NODES_LOG2,
        REG_SCALE
    } reg_idx_t;

    // Configuration register set
    typedef struct packed {
        logic                measure_mode;
        logic                output_enable;
        logic [NL_W-1:0]     nodes_log2;
        logic [SCALE_W-1:0]  scale;
    } cfg_t;

    // Multiplier operand source
    typedef enum logic [1:0] {
        SRC_END,
        SRC_PREV,
        SRC_CURVE,
        SRC_REPORT
    } src_t;

    // Controller to datapath command
    typedef struct packed {
        logic               load;
        logic               issue;
        src_t               src;
        logic [SEP_W-1:0]   sep;
        logic               last;
    } dp_cmd_t;

endpackage

// ===== src/gof_if.sv =====
// Handshake channels of the glyph outline flattener: path commands in, points out.
// Depends on gof_pkg for field widths.
interface gof_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [gof_pkg::OP_W-1:0]             opcode;
    logic signed [gof_pkg::COORD_W-1:0]   end_x;
    logic signed [gof_pkg::COORD_W-1:0]   end_y;
    logic signed [gof_pkg::COORD_W-1:0]   ctrl_x;
    logic signed [gof_pkg::COORD_W-1:0]   ctrl_y;

    modport source (output valid, opcode, end_x, end_y, ctrl_x, ctrl_y, input ready);
    modport sink   (input valid, opcode, end_x, end_y, ctrl_x, ctrl_y, output ready);
endinterface

interface gof_pt_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [gof_pkg::PT_W-1:0]      point_x;
    logic signed [gof_pkg::PT_W-1:0]      point_y;
    logic [gof_pkg::SEP_W-1:0]            separator;
    logic                                 last;

    modport source (output valid, point_x, point_y, separator, last, input ready);
    modport sink   (input valid, point_x, point_y, separator, last, output ready);
endinterface

// ===== src/gof_cfg.sv =====
// APB register block of the glyph outline flattener.
// Holds measure_mode, output_enable, nodes_log2 and scale; depends on gof_pkg.
module gof_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gof_pkg::PADDR_W-1:0]    paddr,
    input  logic [gof_pkg::PDATA_W-1:0]    pwdata,
    output logic [gof_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output gof_pkg::cfg_t                  cfg
);

    gof_pkg::cfg_t     cfg_reg;
    gof_pkg::cfg_t     cfg_next;
    gof_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = gof_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Decode the write into the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                gof_pkg::REG_MEASURE_MODE:  cfg_next.measure_mode  = pwdata[0];
                gof_pkg::REG_OUTPUT_ENABLE: cfg_next.output_enable = pwdata[0];
                gof_pkg::REG_NODES_LOG2:
                    cfg_next.nodes_log2 = pwdata[gof_pkg::NL_W-1:0];
                gof_pkg::REG_SCALE:
                    cfg_next.scale = pwdata[gof_pkg::SCALE_W-1:0];
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.measure_mode  <= 1'b1;
            cfg_reg.output_enable <= 1'b0;
            cfg_reg.nodes_log2    <= 3'd2;
            cfg_reg.scale         <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (idx)
            gof_pkg::REG_MEASURE_MODE:
                prdata = gof_pkg::PDATA_W'(cfg_reg.measure_mode);
            gof_pkg::REG_OUTPUT_ENABLE:
                prdata = gof_pkg::PDATA_W'(cfg_reg.output_enable);
            gof_pkg::REG_NODES_LOG2:
                prdata = gof_pkg::PDATA_W'(cfg_reg.nodes_log2);
            gof_pkg::REG_SCALE:
                prdata = gof_pkg::PDATA_W'(cfg_reg.scale);
        endcase
    end

endmodule

// ===== src/gof_ctrl.sv =====
// Sequencer of the glyph outline flattener: accepts commands and issues point beats.
// Keeps the contour-start flag; drives the datapath through gof_pkg::dp_cmd_t.
module gof_ctrl
#(
    parameter int MAX_NODES_LOG2 = 5
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gof_pkg::OP_W-1:0]    opcode,
    input  gof_pkg::cfg_t               cfg,
    input  logic [((MAX_NODES_LOG2 > 0) ? $clog2(MAX_NODES_LOG2 + 1) : 1)-1:0] nodes_l,
    input  logic                        issue_ok,
    output gof_pkg::dp_cmd_t            cmd
);

    localparam int KW = MAX_NODES_LOG2 + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ONE,
        ST_PREV,
        ST_CURVE
    } state_t;

    state_t                      state_reg, state_next;
    logic                        cs_reg, cs_next;
    logic [gof_pkg::SEP_W-1:0]   sep_reg, sep_next;
    gof_pkg::src_t               src_reg, src_next;
    logic [KW-1:0]               k_reg, k_next;
    logic [KW-1:0]               steps;
    logic                        accept;
    logic                        drawn;

    assign steps    = KW'(1) << nodes_l;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign drawn    = (opcode <= gof_pkg::OP_CUBIC) && !cfg.measure_mode
                      && cfg.output_enable;

    // Command to the datapath for the current state
    always_comb
    begin
        cmd.load  = accept;
        cmd.issue = 1'b0;
        cmd.src   = src_reg;
        cmd.sep   = sep_reg;
        cmd.last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_ONE:
            begin
                cmd.issue = issue_ok;
                cmd.last  = 1'b1;
            end
            ST_PREV:
            begin
                cmd.issue = issue_ok;
                cmd.src   = gof_pkg::SRC_PREV;
            end
            ST_CURVE:
            begin
                cmd.issue = issue_ok;
                cmd.src   = gof_pkg::SRC_CURVE;
                cmd.sep   = gof_pkg::SEP_CONT;
                cmd.last  = (k_reg == steps);
            end
        endcase
    end

    // Next state: decode on accept, advance on each issued beat
    always_comb
    begin
        state_next = state_reg;
        cs_next    = cs_reg;
        sep_next   = sep_reg;
        src_next   = src_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == gof_pkg::OP_BEGIN)
                    begin
                        if (!cfg.measure_mode)
                            cs_next = 1'b1;
                    end
                    else if (opcode == gof_pkg::OP_REPORT)
                    begin
                        state_next = ST_ONE;
                        src_next   = gof_pkg::SRC_REPORT;
                        sep_next   = gof_pkg::SEP_REPORT;
                    end
                    else if (drawn)
                    begin
                        cs_next  = 1'b0;
                        src_next = gof_pkg::SRC_END;
                        if (cs_reg)
                            sep_next = gof_pkg::SEP_FIRST;
                        else if (opcode == gof_pkg::OP_MOVE)
                            sep_next = gof_pkg::SEP_NEW;
                        else
                            sep_next = gof_pkg::SEP_CONT;
                        if (opcode == gof_pkg::OP_QUAD)
                            state_next = ST_PREV;
                        else
                            state_next = ST_ONE;
                    end
                end
            end
            ST_ONE:
            begin
                if (issue_ok)
                    state_next = ST_IDLE;
            end
            ST_PREV:
            begin
                if (issue_ok)
                begin
                    state_next = ST_CURVE;
                    k_next     = '0;
                end
            end
            ST_CURVE:
            begin
                if (issue_ok)
                begin
                    k_next = k_reg + KW'(1);
                    if (k_reg == steps)
                        state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Hold state and sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cs_reg    <= 1'b1;
            sep_reg   <= gof_pkg::SEP_FIRST;
            src_reg   <= gof_pkg::SRC_END;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cs_reg    <= cs_next;
            sep_reg   <= sep_next;
            src_reg   <= src_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== src/gof_dpath.sv =====
// Datapath of the glyph outline flattener: path state, curve difference engine,
// scale multipliers, rounding and the output register. Depends on gof_pkg, gof_pt_if.
module gof_dpath
#(
    parameter int MAX_NODES_LOG2 = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  gof_pkg::dp_cmd_t                    cmd,
    input  logic [gof_pkg::OP_W-1:0]            opcode,
    input  logic signed [gof_pkg::COORD_W-1:0]  end_x,
    input  logic signed [gof_pkg::COORD_W-1:0]  end_y,
    input  logic signed [gof_pkg::COORD_W-1:0]  ctrl_x,
    input  logic signed [gof_pkg::COORD_W-1:0]  ctrl_y,
    input  gof_pkg::cfg_t                       cfg,
    input  logic [((MAX_NODES_LOG2 > 0) ? $clog2(MAX_NODES_LOG2 + 1) : 1)-1:0] nodes_l,
    output logic                                issue_ok,
    gof_pt_if.source                            pt
);

    // Curve numerators reach (2^L)^2 times a 17-bit difference
    localparam int ACCW = 2 * MAX_NODES_LOG2 + gof_pkg::DIFF_W + 1;
    localparam int PW   = ACCW + gof_pkg::MUL_B_W;
    localparam int SHW  = $clog2(2 * MAX_NODES_LOG2 + gof_pkg::PT_SHIFT + 1);

    // Path state
    logic signed [gof_pkg::COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [gof_pkg::COORD_W-1:0] min_x_reg, max_y_reg;

    // Captured operands of the current command
    logic signed [gof_pkg::DIFF_W-1:0]  ex_d_reg, ey_reg, px_d_reg, py_reg;
    logic signed [ACCW-1:0]             nx_reg, dx_reg, ax2_reg;
    logic signed [ACCW-1:0]             ny_reg, dy_reg, ay2_reg;

    // Multiply stage
    logic                               s1_valid_reg;
    logic signed [PW-1:0]               prod_x_reg, prod_y_reg;
    logic [SHW-1:0]                     s1_sh_reg;
    logic [gof_pkg::SEP_W-1:0]          s1_sep_reg;
    logic                               s1_last_reg;

    // Output stage
    logic                               out_valid_reg;
    logic signed [gof_pkg::PT_W-1:0]    out_x_reg, out_y_reg;
    logic [gof_pkg::SEP_W-1:0]          out_sep_reg;
    logic                               out_last_reg;

    logic                               adv;
    logic signed [gof_pkg::DIFF_W-1:0]  ex_d, ey_e, cx_d, cy_e, px_d, py_e;
    logic signed [ACCW-1:0]             px_a, cx_a, ex_a, py_a, cy_a, ey_a;
    logic signed [ACCW-1:0]             ax, bx, ay, by;
    logic signed [ACCW-1:0]             opx, opy;
    logic signed [gof_pkg::MUL_B_W-1:0] mulb;
    logic [SHW-1:0]                     sh;
    logic signed [PW-1:0]               half, sum_x, sum_y, shr_x, shr_y;

    assign adv      = !out_valid_reg || pt.ready;
    assign issue_ok = adv;

    // X differences against the running minimum, y sign-extended, from state before this command
    always_comb
    begin
        px_d = {prev_x_reg[gof_pkg::COORD_W-1], prev_x_reg}
               - {min_x_reg[gof_pkg::COORD_W-1], min_x_reg};
        cx_d = {ctrl_x[gof_pkg::COORD_W-1], ctrl_x}
               - {min_x_reg[gof_pkg::COORD_W-1], min_x_reg};
        ex_d = {end_x[gof_pkg::COORD_W-1], end_x}
               - {min_x_reg[gof_pkg::COORD_W-1], min_x_reg};
        py_e = {prev_y_reg[gof_pkg::COORD_W-1], prev_y_reg};
        cy_e = {ctrl_y[gof_pkg::COORD_W-1], ctrl_y};
        ey_e = {end_y[gof_pkg::COORD_W-1], end_y};
        px_a = ACCW'(px_d);
        cx_a = ACCW'(cx_d);
        ex_a = ACCW'(ex_d);
        py_a = ACCW'(py_e);
        cy_a = ACCW'(cy_e);
        ey_a = ACCW'(ey_e);
        // Second difference is 2A, first step is A + B
        ax = px_a - (cx_a <<< 1) + ex_a;
        ay = py_a - (cy_a <<< 1) + ey_a;
        bx = ((cx_a - px_a) <<< nodes_l) <<< 1;
        by = ((cy_a - py_a) <<< nodes_l) <<< 1;
    end

    // Capture operands on accept, step the difference engine per curve beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ex_d_reg <= ex_d;
            ey_reg   <= ey_e;
            px_d_reg <= px_d;
            py_reg   <= py_e;
            nx_reg   <= (px_a <<< nodes_l) <<< nodes_l;
            ny_reg   <= (py_a <<< nodes_l) <<< nodes_l;
            dx_reg   <= ax + bx;
            dy_reg   <= ay + by;
            ax2_reg  <= ax <<< 1;
            ay2_reg  <= ay <<< 1;
        end
        else if (cmd.issue && (cmd.src == gof_pkg::SRC_CURVE))
        begin
            nx_reg <= nx_reg + dx_reg;
            ny_reg <= ny_reg + dy_reg;
            dx_reg <= dx_reg + ax2_reg;
            dy_reg <= dy_reg + ay2_reg;
        end
    end

    // Update path state and extremes on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            min_x_reg  <= gof_pkg::MIN_X_INIT;
            max_y_reg  <= gof_pkg::MAX_Y_INIT;
        end
        else if (cmd.load)
        begin
            if (cfg.measure_mode)
            begin
                if (opcode == gof_pkg::OP_BEGIN)
                    min_x_reg <= gof_pkg::MIN_X_INIT;
                else if ((opcode <= gof_pkg::OP_CUBIC) && (end_x < min_x_reg))
                    min_x_reg <= end_x;
            end
            else if (opcode <= gof_pkg::OP_CUBIC)
            begin
                prev_x_reg <= end_x;
                prev_y_reg <= end_y;
                if ((opcode != gof_pkg::OP_MOVE) && (end_y > max_y_reg))
                    max_y_reg <= end_y;
            end
        end
    end

    // Select multiplier operands and the rounding shift
    always_comb
    begin
        mulb = $signed({1'b0, cfg.scale});
        sh   = SHW'(gof_pkg::PT_SHIFT);
        unique case (cmd.src)
            gof_pkg::SRC_END:
            begin
                opx = ACCW'(ex_d_reg);
                opy = ACCW'(ey_reg);
            end
            gof_pkg::SRC_PREV:
            begin
                opx = ACCW'(px_d_reg);
                opy = ACCW'(py_reg);
            end
            gof_pkg::SRC_CURVE:
            begin
                opx = nx_reg;
                opy = ny_reg;
                sh  = SHW'({nodes_l, 1'b0}) + SHW'(gof_pkg::PT_SHIFT);
            end
            gof_pkg::SRC_REPORT:
            begin
                opx  = ACCW'(min_x_reg);
                opy  = ACCW'(max_y_reg);
                mulb = gof_pkg::REPORT_GAIN;
            end
        endcase
    end

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= cmd.issue;
    end

    always_ff @(posedge clk)
    begin
        if (adv && cmd.issue)
        begin
            prod_x_reg  <= opx * mulb;
            prod_y_reg  <= opy * mulb;
            s1_sh_reg   <= sh;
            s1_sep_reg  <= cmd.sep;
            s1_last_reg <= cmd.last;
        end
    end

    // Round to nearest, ties toward +infinity
    always_comb
    begin
        half  = PW'(1) << (s1_sh_reg - SHW'(1));
        sum_x = prod_x_reg + half;
        sum_y = prod_y_reg + half;
        shr_x = sum_x >>> s1_sh_reg;
        shr_y = sum_y >>> s1_sh_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            out_x_reg    <= shr_x[gof_pkg::PT_W-1:0];
            out_y_reg    <= shr_y[gof_pkg::PT_W-1:0];
            out_sep_reg  <= s1_sep_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign pt.valid     = out_valid_reg;
    assign pt.point_x   = out_x_reg;
    assign pt.point_y   = out_y_reg;
    assign pt.separator = out_sep_reg;
    assign pt.last      = out_last_reg;

endmodule

// ===== src/glyph_outline_flattener.sv =====
// Glyph outline flattener top level: register block, sequencer and datapath.
// Depends on gof_pkg, gof_if (gof_cmd_if, gof_pt_if), gof_cfg, gof_ctrl, gof_dpath.
//
// Path commands arrive on cmd, points leave on pt, registers sit on the APB port.
// Other than report, commands give no point in a measure pass or with output
// disabled; begin and unused opcodes never give one. Move, line, cubic and report
// give one point. A quadratic gives 2^L + 2 points, one per cycle while pt does
// not stall: the curve samples come from a forward-difference engine (adds only)
// feeding one pair of scale multipliers, which take one point a cycle. An issued
// point passes the multiply stage and the output register; a stalled pt channel
// holds the sequencer. L is nodes_log2, saturated to MAX_NODES_LOG2.
module glyph_outline_flattener
#(
    parameter int MAX_NODES_LOG2 = 5
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    gof_cmd_if.sink                        cmd,
    gof_pt_if.source                       pt,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gof_pkg::PADDR_W-1:0]    paddr,
    input  logic [gof_pkg::PDATA_W-1:0]    pwdata,
    output logic [gof_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int LW = (MAX_NODES_LOG2 > 0) ? $clog2(MAX_NODES_LOG2 + 1) : 1;

    gof_pkg::cfg_t     cfg;
    gof_pkg::dp_cmd_t  dp_cmd;
    logic [LW-1:0]     nodes_l;
    logic              issue_ok;
    logic              in_ready;

    // Saturate the subdivision exponent
    assign nodes_l = (cfg.nodes_log2 > gof_pkg::NL_W'(MAX_NODES_LOG2))
                     ? LW'(MAX_NODES_LOG2) : cfg.nodes_log2[LW-1:0];

    assign cmd.ready = in_ready;

    gof_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gof_ctrl #(.MAX_NODES_LOG2(MAX_NODES_LOG2)) u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .opcode   (cmd.opcode),
        .cfg      (cfg),
        .nodes_l  (nodes_l),
        .issue_ok (issue_ok),
        .cmd      (dp_cmd)
    );

    gof_dpath #(.MAX_NODES_LOG2(MAX_NODES_LOG2)) u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .opcode   (cmd.opcode),
        .end_x    (cmd.end_x),
        .end_y    (cmd.end_y),
        .ctrl_x   (cmd.ctrl_x),
        .ctrl_y   (cmd.ctrl_y),
        .cfg      (cfg),
        .nodes_l  (nodes_l),
        .issue_ok (issue_ok),
        .pt       (pt)
    );

endmodule

// ===== dv/glyph_outline_flattener_test.sv =====
// Testbench for glyph_outline_flattener: directed table then random outline passes.
// Checks every point beat against an in-bench predictor of the flattener.
// Depends on gof_pkg, gof_if (gof_cmd_if, gof_pt_if) and the RTL top level.
`timescale 1ns / 1ps

module glyph_outline_flattener_test;
    import gof_pkg::*;

    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int STEP_LOG2_MAX  = 5;
    localparam int ROUNDS         = 10;
    localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic [SEP_W-1:0]       sep;
        logic                   last;
    } point_t;

    // One directed step: a register write or a command, optionally with a typed result
    typedef struct packed {
        logic                     is_cfg;
        logic [1:0]               ridx;
        logic [PDATA_W-1:0]       rval;
        logic [OP_W-1:0]          op;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic                     typed;
        logic signed [PT_W-1:0]   tx;
        logic signed [PT_W-1:0]   ty;
        logic [SEP_W-1:0]         tsep;
    } step_row_t;

    localparam step_row_t DIRECTED [35] = '{
        '{op: OP_REPORT, typed: 1'b1, tx: 36'sd65536000, ty: -36'sd65536000,
          tsep: SEP_REPORT, default: '0},
        '{op: OP_UNUSED6, ex: 16'sh7FFF, default: '0},
        '{op: OP_UNUSED7, ex: -16'sd1, ey: -16'sd1, cx: -16'sd1, cy: -16'sd1, default: '0},
        '{op: OP_MOVE, ex: 16'sh8000, ey: 16'sd5, default: '0},
        '{op: OP_LINE, ex: 16'sh7FFF, ey: 16'sh7FFF, default: '0},
        '{op: OP_REPORT, typed: 1'b1, tx: -36'sd2147483648, ty: -36'sd65536000,
          tsep: SEP_REPORT, default: '0},
        '{op: OP_BEGIN, default: '0},
        '{op: OP_QUAD, ex: -16'sd5, ey: 16'sd7, cx: 16'sh8000, cy: 16'sh7FFF, default: '0},
        '{op: OP_CUBIC, ex: 16'sd100, ey: -16'sd100, default: '0},
        '{op: OP_REPORT, typed: 1'b1, tx: -36'sd327680, ty: -36'sd65536000,
          tsep: SEP_REPORT, default: '0},
        '{is_cfg: 1'b1, ridx: REG_MEASURE_MODE, rval: 32'd0, default: '0},
        '{is_cfg: 1'b1, ridx: REG_OUTPUT_ENABLE, rval: 32'd1, default: '0},
        '{is_cfg: 1'b1, ridx: REG_NODES_LOG2, rval: 32'd0, default: '0},
        '{is_cfg: 1'b1, ridx: REG_SCALE, rval: 32'h03FF_FFFF, default: '0},
        '{op: OP_MOVE, ex: 16'sh7FFF, ey: 16'sh8000, default: '0},
        '{op: OP_LINE, ex: 16'sh8000, ey: 16'sh7FFF, default: '0},
        '{op: OP_QUAD, ex: 16'sd1, ey: -16'sd1, cx: 16'sh7FFF, cy: 16'sh8000, default: '0},
        '{op: OP_CUBIC, ex: 16'sd0, ey: 16'sd0, default: '0},
        '{is_cfg: 1'b1, ridx: REG_NODES_LOG2, rval: 32'd7, default: '0},
        '{is_cfg: 1'b1, ridx: REG_SCALE, rval: 32'h0100_0000, default: '0},
        '{op: OP_QUAD, ex: 16'sh7FFF, ey: 16'sh8000, cx: 16'sh8000, cy: 16'sh7FFF,
          default: '0},
        '{op: OP_BEGIN, default: '0},
        '{op: OP_MOVE, ex: -16'sd1, ey: -16'sd1, default: '0},
        '{op: OP_MOVE, ex: 16'sd12, ey: 16'sd34, default: '0},
        '{is_cfg: 1'b1, ridx: REG_OUTPUT_ENABLE, rval: 32'd0, default: '0},
        '{op: OP_LINE, ex: 16'sd5, ey: -16'sd6, default: '0},
        '{op: OP_QUAD, ex: 16'sd1, ey: 16'sd2, cx: 16'sd3, cy: 16'sd4, default: '0},
        '{op: OP_CUBIC, ex: -16'sd7, ey: 16'sd8, default: '0},
        '{is_cfg: 1'b1, ridx: REG_OUTPUT_ENABLE, rval: 32'd1, default: '0},
        '{is_cfg: 1'b1, ridx: REG_SCALE, rval: 32'd0, default: '0},
        '{is_cfg: 1'b1, ridx: REG_NODES_LOG2, rval: 32'd3, default: '0},
        '{op: OP_QUAD, ex: -16'sd100, ey: 16'sd200, cx: 16'sd300, cy: -16'sd400,
          default: '0},
        '{op: OP_REPORT, default: '0},
        '{op: OP_UNUSED7, ex: 16'sd9, default: '0},
        '{op: OP_REPORT, default: '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    gof_cmd_if cmd_ch ();
    gof_pt_if  pt_ch ();

    glyph_outline_flattener dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .pt      (pt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the flattener registers and path state
    logic               sh_measure;
    logic               sh_out_en;
    logic [NL_W-1:0]    sh_nodes_log2;
    logic [SCALE_W-1:0] sh_scale;
    int                 sh_prev_x;
    int                 sh_prev_y;
    int                 sh_min_x;
    int                 sh_max_y;
    bit                 sh_contour_start;

    point_t pending_points [$];
    int     mismatches;
    int     cycle_count;
    bit     calm;
    int     src_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Round to nearest, ties toward +infinity
    function automatic longint round_shr(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic point_t scaled_point(int x, int y, logic [SEP_W-1:0] sep);
        point_t p;
        p.x    = PT_W'(round_shr(longint'(x - sh_min_x) * longint'(sh_scale), PT_SHIFT));
        p.y    = PT_W'(round_shr(longint'(y) * longint'(sh_scale), PT_SHIFT));
        p.sep  = sep;
        p.last = 1'b0;
        return p;
    endfunction

    // First point of a pass takes the first-point code and clears the flag
    function automatic logic [SEP_W-1:0] take_sep(logic [SEP_W-1:0] other);
        if (sh_contour_start)
        begin
            sh_contour_start = 1'b0;
            return SEP_FIRST;
        end
        return other;
    endfunction

    // Advance the shadow state by one command and queue the points it gives
    function automatic void predict_points(logic [OP_W-1:0] op,
                                           logic signed [COORD_W-1:0] ex,
                                           logic signed [COORD_W-1:0] ey,
                                           logic signed [COORD_W-1:0] cx,
                                           logic signed [COORD_W-1:0] cy);
        point_t pts [$];
        point_t p;
        int     exi, eyi, cxi, cyi, lg;
        longint steps, nn, a, w0, w1, w2, nx, ny;
        exi = ex;
        eyi = ey;
        cxi = cx;
        cyi = cy;
        if (op == OP_BEGIN)
        begin
            if (sh_measure)
                sh_min_x = MIN_X_INIT;
            else
                sh_contour_start = 1'b1;
        end
        else if (op == OP_REPORT)
        begin
            p.x    = PT_W'(longint'(sh_min_x) * 65536);
            p.y    = PT_W'(longint'(sh_max_y) * 65536);
            p.sep  = SEP_REPORT;
            p.last = 1'b0;
            pts.push_back(p);
        end
        else if (op == OP_UNUSED6 || op == OP_UNUSED7)
        begin
            // ignored
        end
        else if (sh_measure)
        begin
            if (exi < sh_min_x)
                sh_min_x = exi;
        end
        else if (op == OP_MOVE)
        begin
            sh_prev_x = exi;
            sh_prev_y = eyi;
            if (sh_out_en)
                pts.push_back(scaled_point(exi, eyi, take_sep(SEP_NEW)));
        end
        else if (op == OP_QUAD)
        begin
            if (sh_out_en)
            begin
                lg = (sh_nodes_log2 > STEP_LOG2_MAX) ? STEP_LOG2_MAX : int'(sh_nodes_log2);
                steps = longint'(1) << lg;
                nn = steps * steps;
                pts.push_back(scaled_point(sh_prev_x, sh_prev_y, take_sep(SEP_CONT)));
                for (longint k = 0; k <= steps; k++)
                begin
                    a  = steps - k;
                    w0 = a * a;
                    w1 = 2 * a * k;
                    w2 = k * k;
                    nx = w0 * sh_prev_x + w1 * cxi + w2 * exi - longint'(sh_min_x) * nn;
                    ny = w0 * sh_prev_y + w1 * cyi + w2 * eyi;
                    p.x    = PT_W'(round_shr(nx * longint'(sh_scale), 2 * lg + PT_SHIFT));
                    p.y    = PT_W'(round_shr(ny * longint'(sh_scale), 2 * lg + PT_SHIFT));
                    p.sep  = SEP_CONT;
                    p.last = 1'b0;
                    pts.push_back(p);
                end
            end
            sh_prev_x = exi;
            sh_prev_y = eyi;
            if (eyi > sh_max_y)
                sh_max_y = eyi;
        end
        else
        begin
            // line, and cubic drawn as a line to its end point
            if (sh_out_en)
                pts.push_back(scaled_point(exi, eyi, take_sep(SEP_CONT)));
            sh_prev_x = exi;
            sh_prev_y = eyi;
            if (eyi > sh_max_y)
                sh_max_y = eyi;
        end
        if (pts.size() > 0)
            pts[pts.size() - 1].last = 1'b1;
        foreach (pts[i])
            pending_points.push_back(pts[i]);
    endfunction

    function automatic int burst_len(int pct);
        if (calm || $urandom_range(0, 99) >= pct)
            return 0;
        return $urandom_range(1, 19);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return 16'($urandom_range(0, 600)) - 16'd300;
            default: return 16'($urandom());
        endcase
    endfunction

    // Map a draw to one of the four path opcodes
    function automatic logic [OP_W-1:0] path_op(int pick);
        case (pick % 4)
            0:       return OP_MOVE;
            1:       return OP_LINE;
            2:       return OP_QUAD;
            default: return OP_CUBIC;
        endcase
    endfunction

    // Two-phase register write, only called while the block is idle
    task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MEASURE_MODE:  sh_measure    = val[0];
            REG_OUTPUT_ENABLE: sh_out_en     = val[0];
            REG_NODES_LOG2:    sh_nodes_log2 = val[NL_W-1:0];
            REG_SCALE:         sh_scale      = val[SCALE_W-1:0];
            default: ;
        endcase
        // leave the bus idle between writes
        @(posedge clk);
    endtask

    // Drop valid, wait for every expected point, then let the sequencer go quiet
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_cmd(logic [OP_W-1:0] op,
                            logic signed [COORD_W-1:0] ex,
                            logic signed [COORD_W-1:0] ey,
                            logic signed [COORD_W-1:0] cx,
                            logic signed [COORD_W-1:0] cy);
        int gap;
        gap = burst_len(src_pct);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.end_x  <= ex;
        cmd_ch.end_y  <= ey;
        cmd_ch.ctrl_x <= cx;
        cmd_ch.ctrl_y <= cy;
        do @(posedge clk); while (!cmd_ch.ready);
        predict_points(op, ex, ey, cx, cy);
    endtask

    task automatic send_random(logic [OP_W-1:0] op);
        send_cmd(op, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // Point sink: random stall bursts, at a stall level that is redrawn periodically
    initial
    begin
        int stall_left;
        int sink_pct;
        int tick;
        stall_left  = 0;
        sink_pct    = 0;
        tick        = 0;
        pt_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 256 == 0)
                case ($urandom_range(0, 2))
                    0:       sink_pct = 0;
                    1:       sink_pct = 4;
                    default: sink_pct = 25;
                endcase
            if (!rst_n)
                pt_ch.ready <= 1'b0;
            else if (calm)
            begin
                stall_left = 0;
                pt_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pt_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < sink_pct)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                pt_ch.ready <= 1'b0;
            end
            else
                pt_ch.ready <= 1'b1;
        end
    end

    // Compare each point beat with the oldest expectation
    always @(posedge clk)
    begin : check_points
        point_t want;
        if (rst_n && pt_ch.valid && pt_ch.ready)
        begin
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d sep=%0d last=%0d",
                             pt_ch.point_x, pt_ch.point_y, pt_ch.separator, pt_ch.last);
            end
            else
            begin
                want = pending_points.pop_front();
                if (pt_ch.point_x !== want.x || pt_ch.point_y !== want.y ||
                    pt_ch.separator !== want.sep || pt_ch.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"point mismatch: want x=%0d y=%0d sep=%0d last=%0d, ",
                                  "got %0d %0d %0d %0d"},
                                 want.x, want.y, want.sep, want.last,
                                 pt_ch.point_x, pt_ch.point_y, pt_ch.separator,
                                 pt_ch.last);
                end
            end
        end
    end

    // Cycle counter guards against a hang
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int        emitted;
        int        target;
        int        pick;
        logic [OP_W-1:0]    op;
        logic [NL_W-1:0]    nl;
        logic [SCALE_W-1:0] sc;
        logic               oe;

        // Hold every input at a known value through reset
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.opcode  = OP_MOVE;
        cmd_ch.end_x   = '0;
        cmd_ch.end_y   = '0;
        cmd_ch.ctrl_x  = '0;
        cmd_ch.ctrl_y  = '0;
        mismatches     = 0;
        calm           = 1'b0;
        src_pct        = 20;
        sh_measure       = 1'b1;
        sh_out_en        = 1'b0;
        sh_nodes_log2    = 3'd2;
        sh_scale         = '0;
        sh_prev_x        = 0;
        sh_prev_y        = 0;
        sh_min_x         = MIN_X_INIT;
        sh_max_y         = MAX_Y_INIT;
        sh_contour_start = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].is_cfg)
            begin
                settle();
                reg_write(reg_idx_t'(DIRECTED[i].ridx), DIRECTED[i].rval);
            end
            else
            begin
                send_cmd(DIRECTED[i].op, DIRECTED[i].ex, DIRECTED[i].ey,
                         DIRECTED[i].cx, DIRECTED[i].cy);
                // typed value replaces the computed one for this report
                if (DIRECTED[i].typed)
                    pending_points[pending_points.size() - 1] =
                        '{x: DIRECTED[i].tx, y: DIRECTED[i].ty,
                          sep: DIRECTED[i].tsep, last: 1'b1};
            end
        end

        // Random rounds: a measure pass, then an emit pass of contours
        for (int round = 0; round < ROUNDS; round++)
        begin
            calm = (round == ROUNDS - 1);
            case ($urandom_range(0, 2))
                0:       src_pct = 0;
                1:       src_pct = 10;
                default: src_pct = 35;
            endcase

            settle();
            reg_write(REG_MEASURE_MODE, 32'd1);
            if ($urandom_range(0, 3) != 0)
                send_random(OP_BEGIN);
            repeat ($urandom_range(8, 14))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    op = ($urandom_range(0, 1) != 0) ? OP_UNUSED6 : OP_UNUSED7;
                else if (pick < 10)
                    op = OP_REPORT;
                else
                    op = path_op(pick);
                send_random(op);
            end
            send_random(OP_REPORT);

            // Emit settings: extremes on the early rounds
            case (round)
                0:       nl = 3'd5;
                1:       nl = 3'd7;
                2:       nl = 3'd0;
                default: nl = ($urandom_range(0, 4) == 0) ? NL_W'($urandom_range(4, 6))
                                                          : NL_W'($urandom_range(0, 3));
            endcase
            case (round)
                3:       sc = '1;
                4:       sc = '0;
                5:       sc = SCALE_W'(32'h0100_0000);
                default: sc = SCALE_W'($urandom());
            endcase
            oe = (round == 6) ? 1'b0 : ($urandom_range(0, 7) != 0);
            settle();
            reg_write(REG_MEASURE_MODE, 32'd0);
            reg_write(REG_OUTPUT_ENABLE, {31'd0, oe});
            reg_write(REG_NODES_LOG2, {29'd0, nl});
            reg_write(REG_SCALE, {6'd0, sc});

            emitted = 0;
            target  = $urandom_range(22, 32);
            send_random(OP_BEGIN);
            while (emitted < target)
            begin
                send_random(OP_MOVE);
                emitted++;
                repeat ($urandom_range(1, 6))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        op = OP_W'($urandom_range(0, 7));
                    else if (pick < 40)
                        op = OP_LINE;
                    else if (pick < 85)
                        op = OP_QUAD;
                    else
                        op = OP_CUBIC;
                    send_random(op);
                    emitted++;
                end
                // hold off the sender until the block has drained
                if (!calm && $urandom_range(0, 7) == 0)
                    settle();
            end
            if ($urandom_range(0, 1) != 0)
                send_random(OP_REPORT);
        end

        settle();
        if (mismatches == 0 && pending_points.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gof_pkg.sv
src/gof_if.sv
src/gof_cfg.sv
src/gof_ctrl.sv
src/gof_dpath.sv
src/glyph_outline_flattener.sv
dv/glyph_outline_flattener_test.sv
